// ----- hdl/pte_pkg.sv -----
// ----------------------------------------------------------------------------
// pte_pkg
// Shared types, operation codes and cell commands of the permutation table.
// ----------------------------------------------------------------------------
package pte_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;

    // operation kinds carried by an input item
    localparam logic [2:0] KIND_RESIZE  = 3'd0;
    localparam logic [2:0] KIND_WRITE   = 3'd1;
    localparam logic [2:0] KIND_READ    = 3'd2;
    localparam logic [2:0] KIND_MOVE    = 3'd3;
    localparam logic [2:0] KIND_RM_OLD  = 3'd4;
    localparam logic [2:0] KIND_RM_NEW  = 3'd5;

    // commands broadcast to every cell
    localparam logic [2:0] CELL_HOLD    = 3'd0;
    localparam logic [2:0] CELL_ROTATE  = 3'd1;
    localparam logic [2:0] CELL_WRITE   = 3'd2;
    localparam logic [2:0] CELL_RESIZE  = 3'd3;
    localparam logic [2:0] CELL_MOVE    = 3'd4;
    localparam logic [2:0] CELL_REMOVE  = 3'd5;

    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] old_index;
        logic [5:0] new_index;
        logic [6:0] count_value;
    } in_item_t;

    typedef struct packed {
        logic [5:0] mapped_value;
        logic [5:0] inverse_position;
        logic       is_permutation;
        logic [6:0] entry_count;
        logic       error;
    } out_item_t;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] old_idx;
        logic [5:0] new_idx;
        logic [6:0] count;
        logic [6:0] used;
        logic [5:0] rm_pos;
        logic [5:0] gone;
    } cell_cmd_t;

endpackage

// ----- hdl/pte_cell.sv -----
// ----------------------------------------------------------------------------
// pte_cell
// One table entry. Updates itself from a broadcast command and its neighbor.
// ----------------------------------------------------------------------------
module pte_cell
    import pte_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic       clk,
    input  cell_cmd_t  cmd,
    input  logic [5:0] nbr,
    output logic [5:0] value
);

    logic [5:0] value_reg;
    logic [5:0] value_next;
    logic [5:0] base;

    always_comb
    begin
        value_next = value_reg;
        base       = (IDX >= int'(cmd.rm_pos)) ? nbr : value_reg;
        unique case (cmd.op)
            CELL_HOLD:   value_next = value_reg;
            CELL_ROTATE: value_next = nbr;
            CELL_WRITE:
            begin
                if (int'(cmd.old_idx) == IDX)
                    value_next = cmd.new_idx;
            end
            CELL_RESIZE:
            begin
                if (IDX >= int'(cmd.used) && IDX < int'(cmd.count))
                    value_next = 6'(IDX);
            end
            CELL_MOVE:
            begin
                if (value_reg == cmd.old_idx)
                    value_next = cmd.new_idx;
                else if (cmd.old_idx > cmd.new_idx && value_reg < cmd.old_idx
                         && value_reg >= cmd.new_idx)
                    value_next = value_reg + 6'd1;
                else if (cmd.old_idx < cmd.new_idx && value_reg > cmd.old_idx
                         && value_reg <= cmd.new_idx)
                    value_next = value_reg - 6'd1;
            end
            CELL_REMOVE:
            begin
                // close the gap, then renumber values above the removed one
                value_next = (base > cmd.gone) ? base - 6'd1 : base;
            end
            default:     value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- hdl/permutation_table_engine_core.sv -----
// ----------------------------------------------------------------------------
// permutation_table_engine_core
// Index permutation table held in a ring of cells, with a scanning sequencer.
// ----------------------------------------------------------------------------
// An item is accepted only while the block is idle, and in_stall stays high
// from the accepting edge until the result is in the output register. A full
// rotation of the cell ring past the head checks the permutation and finds the
// looked-up entries, the apply state updates the entry in every cell at once, a
// second rotation checks the permutation again for the result, and the final
// state loads the output register. The block returns to idle as that register
// is loaded, so it takes no new item before it is through with the last one.
// While a stalled receiver still holds the previous result, the block waits in
// its final state with its input stalled.
module permutation_table_engine_core
    import pte_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    localparam int CW = $clog2(TABLE_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN1 = 3'd1;
    localparam logic [2:0] ST_APPLY = 3'd2;
    localparam logic [2:0] ST_SCAN2 = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] pos_reg;
    logic [6:0]    used_reg;
    in_item_t      item_reg;
    logic [63:0]   seen_reg;
    logic          perm_reg, found_reg, err_reg;
    logic [5:0]    mapped_reg, fpos_reg;
    logic          out_valid_reg;
    out_item_t     out_item_reg;

    logic [5:0]    vals [TABLE_DEPTH];
    cell_cmd_t     cmd;
    logic [5:0]    head;
    logic          in_use, last;
    logic          oi_bad, ni_bad, apply_err;
    logic [2:0]    apply_op;
    logic [6:0]    used_after;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            pte_cell #(.IDX(g)) u_cell
            (
                .clk   (clk),
                .cmd   (cmd),
                .nbr   (vals[(g + 1) % TABLE_DEPTH]),
                .value (vals[g])
            );
        end
    endgenerate

    assign head   = vals[0];
    assign in_use = int'(pos_reg) < int'(used_reg);
    assign last   = int'(pos_reg) == TABLE_DEPTH - 1;
    assign oi_bad = {1'b0, item_reg.old_index} >= used_reg;
    assign ni_bad = {1'b0, item_reg.new_index} >= used_reg;

    always_comb
    begin
        apply_err  = 1'b0;
        apply_op   = CELL_HOLD;
        used_after = used_reg;
        unique case (item_reg.kind)
            KIND_RESIZE:
            begin
                apply_err = int'(item_reg.count_value) > TABLE_DEPTH;
                apply_op  = CELL_RESIZE;
                if (!apply_err)
                    used_after = item_reg.count_value;
            end
            KIND_WRITE:
            begin
                apply_err = oi_bad;
                apply_op  = CELL_WRITE;
            end
            KIND_READ:
            begin
                apply_err = oi_bad || !found_reg;
            end
            KIND_MOVE:
            begin
                apply_err = oi_bad || ni_bad || !perm_reg;
                apply_op  = (item_reg.old_index == item_reg.new_index) ? CELL_HOLD : CELL_MOVE;
            end
            KIND_RM_OLD:
            begin
                apply_err = oi_bad || !perm_reg;
                apply_op  = CELL_REMOVE;
                if (!apply_err)
                    used_after = used_reg - 7'd1;
            end
            KIND_RM_NEW:
            begin
                apply_err = ni_bad || !perm_reg || !found_reg;
                apply_op  = CELL_REMOVE;
                if (!apply_err)
                    used_after = used_reg - 7'd1;
            end
            default:
            begin
                apply_err = 1'b1;
            end
        endcase
        if (apply_err)
            apply_op = CELL_HOLD;
    end

    always_comb
    begin
        cmd.op      = CELL_HOLD;
        cmd.old_idx = item_reg.old_index;
        cmd.new_idx = item_reg.new_index;
        cmd.count   = item_reg.count_value;
        cmd.used    = used_reg;
        cmd.rm_pos  = (item_reg.kind == KIND_RM_OLD) ? item_reg.old_index : fpos_reg;
        cmd.gone    = (item_reg.kind == KIND_RM_OLD) ? mapped_reg : item_reg.new_index;
        if (state_reg == ST_SCAN1 || state_reg == ST_SCAN2)
            cmd.op = CELL_ROTATE;
        else if (state_reg == ST_APPLY)
            cmd.op = apply_op;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_SCAN1;
            ST_SCAN1: if (last) state_next = ST_APPLY;
            ST_APPLY: state_next = ST_SCAN2;
            ST_SCAN2: if (last) state_next = ST_FIN;
            ST_FIN:   if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_APPLY)
                used_reg <= used_after;
            if (state_reg == ST_FIN && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                item_reg   <= in_item;
                pos_reg    <= '0;
                seen_reg   <= '0;
                perm_reg   <= 1'b1;
                found_reg  <= 1'b0;
                mapped_reg <= 6'd0;
                fpos_reg   <= 6'd0;
            end
            ST_SCAN1:
            begin
                pos_reg <= last ? '0 : pos_reg + CW'(1);
                if (in_use)
                begin
                    if ({1'b0, head} >= used_reg || seen_reg[head])
                        perm_reg <= 1'b0;
                    seen_reg[head] <= 1'b1;
                    if (int'(pos_reg) == int'(item_reg.old_index))
                        mapped_reg <= head;
                    if (head == item_reg.new_index && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        fpos_reg  <= 6'(pos_reg);
                    end
                end
            end
            ST_APPLY:
            begin
                err_reg  <= apply_err;
                seen_reg <= '0;
                perm_reg <= 1'b1;
            end
            ST_SCAN2:
            begin
                pos_reg <= last ? '0 : pos_reg + CW'(1);
                if (in_use)
                begin
                    if ({1'b0, head} >= used_reg || seen_reg[head])
                        perm_reg <= 1'b0;
                    seen_reg[head] <= 1'b1;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_item_reg.mapped_value     <= (item_reg.kind == KIND_READ)
                                                     ? mapped_reg : 6'd0;
                    out_item_reg.inverse_position <= (item_reg.kind == KIND_READ && found_reg)
                                                     ? fpos_reg : 6'd0;
                    out_item_reg.is_permutation   <= perm_reg;
                    out_item_reg.entry_count      <= used_reg;
                    out_item_reg.error            <= err_reg;
                end
            end
            default:
            begin
                pos_reg <= '0;
            end
        endcase
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the permutation table engine with directed and random operations
// and checks every result against a behavioral copy of the table, under
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import pte_pkg::*;

    localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 2 * DEPTH + 40;

    // kind codes with no operation behind them
    localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

    class perm_scoreboard;
        logic [5:0]  perm_table [DEPTH];
        int          used_count;
        out_item_t   expected_q [$];
        int          mismatches;

        function new();
            used_count = 0;
            mismatches = 0;
            foreach (perm_table[i]) perm_table[i] = '0;
        endfunction

        function bit is_perm();
            bit seen [DEPTH];
            foreach (seen[i]) seen[i] = 0;
            for (int i = 0; i < used_count; i++) begin
                if (perm_table[i] >= used_count || seen[perm_table[i]]) return 0;
                seen[perm_table[i]] = 1;
            end
            return 1;
        endfunction

        function bit find_pos(input int val, output int pos);
            pos = 0;
            for (int i = 0; i < used_count; i++) begin
                if (perm_table[i] == val)
                begin
                    pos = i;
                    return 1;
                end
            end
            return 0;
        endfunction

        function void drop_entry(input int pos);
            int gone;
            int w;
            gone = perm_table[pos];
            w = 0;
            for (int i = 0; i < used_count; i++) begin
                if (i != pos)
                begin
                    perm_table[w] = (perm_table[i] > gone) ? 6'(perm_table[i] - 6'd1)
                                                           : perm_table[i];
                    w++;
                end
            end
            used_count--;
        endfunction

        // predict the result of one accepted item and queue it
        function void note_input(input in_item_t it);
            out_item_t r;
            int oi;
            int ni;
            int cnt;
            int pos;
            bit err;
            oi = int'(it.old_index);
            ni = int'(it.new_index);
            cnt = int'(it.count_value);
            err = 0;
            r = '0;
            case (it.kind)
                KIND_RESIZE:
                begin
                    if (cnt > DEPTH) err = 1;
                    else
                    begin
                        for (int i = used_count; i < cnt; i++) perm_table[i] = i[5:0];
                        used_count = cnt;
                    end
                end
                KIND_WRITE:
                begin
                    if (oi >= used_count) err = 1;
                    else perm_table[oi] = ni[5:0];
                end
                KIND_READ:
                begin
                    if (oi >= used_count) err = 1;
                    else r.mapped_value = perm_table[oi];
                    if (find_pos(ni, pos)) r.inverse_position = pos[5:0];
                    else err = 1;
                end
                KIND_MOVE:
                begin
                    if (oi >= used_count || ni >= used_count || !is_perm()) err = 1;
                    else if (oi != ni && find_pos(oi, pos))
                    begin
                        for (int i = 0; i < used_count; i++) begin
                            if (oi > ni)
                            begin
                                if (perm_table[i] < oi && perm_table[i] >= ni)
                                    perm_table[i] = 6'(perm_table[i] + 6'd1);
                            end
                            else if (perm_table[i] > oi && perm_table[i] <= ni)
                                perm_table[i] = 6'(perm_table[i] - 6'd1);
                        end
                        perm_table[pos] = ni[5:0];
                    end
                end
                KIND_RM_OLD:
                begin
                    if (oi >= used_count || !is_perm()) err = 1;
                    else drop_entry(oi);
                end
                KIND_RM_NEW:
                begin
                    if (ni >= used_count || !is_perm() || !find_pos(ni, pos)) err = 1;
                    else drop_entry(pos);
                end
                default: err = 1;
            endcase
            r.is_permutation = is_perm();
            r.entry_count = used_count[6:0];
            r.error = err;
            expected_q.push_back(r);
        endfunction

        function void check_result(input out_item_t got);
            out_item_t exp;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            exp = expected_q.pop_front();
            if (got.mapped_value !== exp.mapped_value
                || got.inverse_position !== exp.inverse_position
                || got.is_permutation !== exp.is_permutation
                || got.entry_count !== exp.entry_count
                || got.error !== exp.error)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", exp, got);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    perm_scoreboard sb;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_off_cycles;
    int cycle_count;

    permutation_table_engine_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: long hold-off first, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    end

    // offer one item, with random idle cycles ahead of it, and hold until accepted;
    // valid stays high after acceptance until the next item or a drain drops it
    task automatic send_item(input in_item_t it);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(it);
        @(negedge clk);
    endtask

    task automatic send_op(input logic [2:0] k, input int oi, input int ni, input int cnt);
        in_item_t it;
        it.kind = k;
        it.old_index = oi[5:0];
        it.new_index = ni[5:0];
        it.count_value = cnt[6:0];
        send_item(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
    endtask

    // mostly in-range indices against the current count, some fully random
    function automatic in_item_t make_item();
        in_item_t it;
        int sel;
        int top;
        sel = $urandom_range(99);
        top = (sb.used_count > 0) ? sb.used_count - 1 : 0;
        it.old_index = ($urandom_range(99) < 85) ? 6'($urandom_range(top))
                                                 : 6'($urandom_range(63));
        it.new_index = ($urandom_range(99) < 85) ? 6'($urandom_range(top))
                                                 : 6'($urandom_range(63));
        it.count_value = ($urandom_range(99) < 93) ? 7'($urandom_range(DEPTH))
                                                    : 7'($urandom_range(127));
        if (sel < 15)      it.kind = KIND_RESIZE;
        else if (sel < 25) it.kind = KIND_WRITE;
        else if (sel < 50) it.kind = KIND_READ;
        else if (sel < 70) it.kind = KIND_MOVE;
        else if (sel < 82) it.kind = KIND_RM_OLD;
        else if (sel < 94) it.kind = KIND_RM_NEW;
        else               it.kind = ($urandom_range(1) != 0) ? KIND_UNUSED_HI
                                                               : KIND_UNUSED_LO;
        return it;
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) send_item(make_item());
        drain();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_cycles = 0;
        cycle_count = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty table, extremes, every kind and error path
        send_op(KIND_READ,   0,  0,   0);
        send_op(KIND_MOVE,   0,  0,   0);
        send_op(KIND_RESIZE, 0,  0, 127);
        send_op(KIND_RESIZE, 0,  0,  65);
        send_op(KIND_RESIZE, 0,  0,  64);
        send_op(KIND_READ,  63, 63,   0);
        send_op(KIND_MOVE,  63,  0,   0);
        send_op(KIND_MOVE,   0, 63,   0);
        send_op(KIND_MOVE,  17, 17,   0);
        send_op(KIND_RM_OLD, 63, 0,   0);
        send_op(KIND_RM_NEW, 0, 62,   0);
        send_op(KIND_READ,  63, 63,   0);
        send_op(KIND_RESIZE, 0,  0,   8);
        send_op(KIND_WRITE,  3,  7,   0);
        send_op(KIND_READ,   3,  3,   0);
        send_op(KIND_MOVE,   1,  2,   0);
        send_op(KIND_RM_OLD, 1,  0,   0);
        send_op(KIND_RM_NEW, 0,  1,   0);
        send_op(KIND_WRITE,  8,  1,   0);
        send_op(KIND_RESIZE, 0,  0,   0);
        send_op(KIND_RESIZE, 0,  0,   5);
        send_op(KIND_UNUSED_LO, 0,  0,   0);
        send_op(KIND_UNUSED_HI, 63, 63, 127);
        drain();

        run_phase(0, 0, 150);
        // fill the block while the receiver holds off
        hold_off_cycles = 600;
        run_phase(45, 0, 160);
        run_phase(0, 45, 160);
        run_phase(32, 32, 160);

        repeat (DRAIN_WAIT) @(negedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/pte_pkg.sv
hdl/pte_cell.sv
hdl/permutation_table_engine_core.sv
tb/testbench.sv
